// ----- rtl/lmpd_pkg.sv -----
`default_nettype none

package lmpd_pkg;

  // Fixed field widths.
  localparam int X_W       = 32;
  localparam int STEP_W    = 16;
  localparam int PERIOD_W  = 7;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GROWTH_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_VALUE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT    = 2'd2;

  // Configuration reset values: r = 3.5, x = 0.5, limit = 20000.
  localparam logic [X_W-1:0]    GROWTH_RATE_RST   = 32'hE000_0000;
  localparam logic [X_W-1:0]    INITIAL_VALUE_RST = 32'h8000_0000;
  localparam logic [STEP_W-1:0] STEP_LIMIT_RST    = 16'd20000;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_RUNNING   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SETTLED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PERIODIC  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TROUBLE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_PERIOD = 3'd4;

  // Settled tolerance: x >> 20 stands in for a relative 1e-6.
  localparam int SETTLE_SHIFT = 20;

endpackage

`default_nettype wire

// ----- rtl/lmpd_history.sv -----
`default_nettype none

module lmpd_history #(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [ADDR_W-1:0]        waddr,
  input  wire logic [lmpd_pkg::X_W-1:0] wdata,
  input  wire logic                     re,
  input  wire logic [ADDR_W-1:0]        raddr,
  output logic      [lmpd_pkg::X_W-1:0] rdata
);
  import lmpd_pkg::*;

  logic [X_W-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lmpd_map.sv -----
`default_nettype none

module lmpd_map (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [lmpd_pkg::X_W-1:0] x,
  input  wire logic [lmpd_pkg::X_W-1:0] rate,
  output logic                          done,
  output logic      [lmpd_pkg::X_W-1:0] y
);
  import lmpd_pkg::*;

  logic                 v1;
  logic                 v2;
  logic                 v3;
  logic [X_W-1:0]       x1;
  logic [2*X_W-1:0]     sq;
  logic [2*X_W-1:0]     prod1;
  logic [2*X_W-1:0]     diff;
  logic [X_W-1:0]       p;
  logic [2*X_W-1:0]     prod2;

  // x * (1 - x) is x * 2^32 - x * x; the subtraction waits for the square.
  assign sq   = {{X_W{1'b0}}, x} * {{X_W{1'b0}}, x};
  assign diff = {x1, {X_W{1'b0}}} - prod1;

  // Stage valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Square, subtract, then multiply by the rate.
  always_ff @(posedge clk) begin
    x1    <= x;
    prod1 <= sq;
    p     <= diff[2*X_W-1:X_W];
    prod2 <= {{X_W{1'b0}}, rate} * {{X_W{1'b0}}, p};
  end

  // Rate is Q2.30, so drop 30 bits and saturate anything above 32 bits.
  assign done = v3;
  assign y    = (prod2[2*X_W-1:2*X_W-2] != 2'b00) ? {X_W{1'b1}} : prod2[2*X_W-3:30];

endmodule

`default_nettype wire

// ----- rtl/logistic_map_period_detector.sv -----
`default_nettype none
// A step that is not settled scans the history before its result beat; a step
// that settles skips the scan, and one taken while a final status is held goes
// straight to the result. One step is in flight at a time, and the history scan
// reads one past value a cycle through the single read port.
// Reset clears all run state, x starts at 0.5, and the history reads as zero
// through a fill count, so no clearing pass is needed.

module logistic_map_period_detector #(
  parameter int HISTORY_DEPTH = 128
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [lmpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lmpd_pkg::X_W-1:0]           cfg_data,
  input  wire logic                               step_valid,
  output logic                                    step_stall,
  input  wire logic                               restart,
  output logic                                    result_valid,
  input  wire logic                               result_stall,
  output logic      [lmpd_pkg::X_W-1:0]           value,
  output logic                                    repeat_seen,
  output logic      [lmpd_pkg::PERIOD_W-1:0]      period,
  output logic      [lmpd_pkg::STATUS_W-1:0]      status
);
  import lmpd_pkg::*;

  localparam int LAG_W  = $clog2(HISTORY_DEPTH);
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SAME_W = LAG_W + 1;
  localparam int CHG_W  = $clog2(2 * HISTORY_DEPTH + 3);

  localparam logic [LAG_W-1:0]  LAST_SLOT  = LAG_W'(HISTORY_DEPTH - 1);
  localparam logic [LAG_W-1:0]  TWO_SLOTS  = LAG_W'(2);
  localparam logic [LAG_W-1:0]  WRAP_TWO   = LAG_W'(HISTORY_DEPTH - 2);
  localparam logic [FILL_W-1:0] FIRST_LAG  = FILL_W'(2);
  localparam logic [FILL_W-1:0] LAST_LAG   = FILL_W'(HISTORY_DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL       = FILL_W'(HISTORY_DEPTH);
  localparam logic [CHG_W-1:0]  CHG_LIMIT  = CHG_W'(2 * HISTORY_DEPTH);

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MAP    = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_LIMIT  = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0]          state;

  // Configuration registers.
  logic [X_W-1:0]      growth_rate;
  logic [X_W-1:0]      initial_value;
  logic [STEP_W-1:0]   step_limit;

  // Run state.
  logic [X_W-1:0]      current_x;
  logic [LAG_W-1:0]    slot;
  logic [FILL_W-1:0]   fill;
  logic [LAG_W-1:0]    tracked;
  logic [SAME_W-1:0]   same_cnt;
  logic [CHG_W-1:0]    chg_cnt;
  logic [STEP_W-1:0]   step_idx;
  logic [STATUS_W-1:0] final_st;
  logic                matched;

  // Scan control.
  logic                prev_load;
  logic [X_W-1:0]      prev;
  logic                issue_act;
  logic [LAG_W-1:0]    scan_addr;
  logic [FILL_W-1:0]   issue_lag;
  logic                cmp_valid;
  logic [FILL_W-1:0]   cmp_lag;

  // Datapath wires.
  logic                step_acc;
  logic                go_map;
  logic                map_start;
  logic                map_done;
  logic [X_W-1:0]      map_x;
  logic [X_W-1:0]      map_y;
  logic [X_W-1:0]      diff;
  logic                settled;
  logic [LAG_W-1:0]    slot_inc;
  logic [LAG_W-1:0]    scan_start;
  logic [LAG_W-1:0]    scan_dec;
  logic                hist_we;
  logic                hist_re;
  logic [LAG_W-1:0]    hist_raddr;
  logic [X_W-1:0]      hist_rdata;
  logic                scan_rd;
  logic [X_W-1:0]      cmp_val;
  logic                hit;
  logic                scan_end;
  logic [LAG_W-1:0]    hit_lag;
  logic [STEP_W-1:0]   hit_lag_ext;
  logic                same_period;
  logic [SAME_W-1:0]   same_inc;
  logic                same_over;
  logic                chg_over;

  // Handshake: one step in flight; the output register frees the input side.
  assign step_stall = (state != S_IDLE);
  assign step_acc   = step_valid && !step_stall;
  assign go_map     = restart || (final_st == ST_RUNNING);
  assign map_start  = step_acc && go_map;
  assign map_x      = restart ? initial_value : current_x;

  lmpd_map u_map (
    .clk   (clk),
    .rst   (rst),
    .start (map_start),
    .x     (map_x),
    .rate  (growth_rate),
    .done  (map_done),
    .y     (map_y)
  );

  // Slot arithmetic wraps at the history depth.
  assign slot_inc   = (slot == LAST_SLOT) ? '0 : slot + 1'b1;
  assign scan_start = (slot_inc >= TWO_SLOTS) ? slot_inc - TWO_SLOTS : slot_inc + WRAP_TWO;
  assign scan_dec   = (scan_addr == '0) ? LAST_SLOT : scan_addr - 1'b1;

  // Settled test against the previous newest value.
  assign diff    = (map_y >= prev) ? map_y - prev : prev - map_y;
  assign settled = (diff <= (map_y >> SETTLE_SHIFT));

  // History port: previous value read on the step beat, lags read during the scan.
  assign scan_rd    = (state == S_SCAN) && issue_act && !hit;
  assign hist_we    = (state == S_MAP) && map_done;
  assign hist_re    = step_acc || scan_rd;
  assign hist_raddr = (state == S_SCAN) ? scan_addr : slot;

  lmpd_history #(
    .DEPTH  (HISTORY_DEPTH),
    .ADDR_W (LAG_W)
  ) u_history (
    .clk   (clk),
    .we    (hist_we),
    .waddr (slot_inc),
    .wdata (map_y),
    .re    (hist_re),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // Entries not yet written since the restart read as zero.
  assign cmp_val  = (cmp_lag < fill) ? hist_rdata : '0;
  assign hit      = (state == S_SCAN) && cmp_valid && (cmp_val == current_x);
  assign scan_end = (state == S_SCAN) && cmp_valid && !hit && (cmp_lag == LAST_LAG);

  // Period bookkeeping on a match.
  assign hit_lag     = LAG_W'(cmp_lag);
  assign hit_lag_ext = STEP_W'(cmp_lag);
  assign same_period = (tracked == hit_lag);
  assign same_inc    = same_cnt + 1'b1;
  assign same_over   = (same_inc > {tracked, 1'b0});
  assign chg_over    = (chg_cnt > CHG_LIMIT);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      growth_rate   <= GROWTH_RATE_RST;
      initial_value <= INITIAL_VALUE_RST;
      step_limit    <= STEP_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GROWTH_RATE:   growth_rate   <= cfg_data;
        REG_INITIAL_VALUE: initial_value <= cfg_data;
        REG_STEP_LIMIT:    step_limit    <= cfg_data[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Scan payload registers.
  always_ff @(posedge clk) begin
    if (prev_load) begin
      prev <= (fill != '0) ? hist_rdata : '0;
    end
    cmp_lag <= issue_lag;
  end

  // Step sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      current_x    <= INITIAL_VALUE_RST;
      slot         <= '0;
      fill         <= '0;
      tracked      <= '0;
      same_cnt     <= '0;
      chg_cnt      <= '0;
      step_idx     <= '0;
      final_st     <= ST_RUNNING;
      matched      <= 1'b0;
      prev_load    <= 1'b0;
      issue_act    <= 1'b0;
      cmp_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      prev_load <= map_start;
      cmp_valid <= scan_rd;

      // Output register: filled by a finished step, emptied by an accepted beat.
      if ((state == S_RESULT) && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (step_acc) begin
            matched <= 1'b0;
            if (restart) begin
              current_x <= initial_value;
              slot      <= '0;
              fill      <= '0;
              tracked   <= '0;
              same_cnt  <= '0;
              chg_cnt   <= '0;
              step_idx  <= '0;
              final_st  <= ST_RUNNING;
            end
            state <= go_map ? S_MAP : S_RESULT;
          end
        end

        S_MAP: begin
          if (map_done) begin
            current_x <= map_y;
            slot      <= slot_inc;
            if (fill != FULL) begin
              fill <= fill + 1'b1;
            end
            if (settled) begin
              final_st <= ST_SETTLED;
              state    <= S_RESULT;
            end else begin
              scan_addr <= scan_start;
              issue_lag <= FIRST_LAG;
              issue_act <= 1'b1;
              state     <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          // Issue one lag a cycle, compare in the cycle after.
          if (scan_rd) begin
            scan_addr <= scan_dec;
            issue_lag <= issue_lag + 1'b1;
            if (issue_lag == LAST_LAG) begin
              issue_act <= 1'b0;
            end
          end
          if (hit) begin
            matched   <= 1'b1;
            issue_act <= 1'b0;
            if (same_period) begin
              same_cnt <= same_inc;
            end else begin
              chg_cnt <= chg_cnt + 1'b1;
            end
            if (same_period && same_over) begin
              final_st <= ST_PERIODIC;
            end else if (!same_period && chg_over) begin
              final_st <= ST_TROUBLE;
            end else begin
              tracked <= hit_lag;
              if (step_idx > hit_lag_ext) begin
                step_idx <= step_idx - hit_lag_ext;
              end
            end
            state <= S_LIMIT;
          end else if (scan_end) begin
            issue_act <= 1'b0;
            state     <= S_LIMIT;
          end
        end

        S_LIMIT: begin
          if (final_st == ST_RUNNING) begin
            if (step_idx >= step_limit) begin
              final_st <= ST_NO_PERIOD;
            end else begin
              step_idx <= step_idx + 1'b1;
            end
          end
          state <= S_RESULT;
        end

        S_RESULT: begin
          if (!result_valid || !result_stall) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result beat payload.
  always_ff @(posedge clk) begin
    if ((state == S_RESULT) && (!result_valid || !result_stall)) begin
      value       <= current_x;
      repeat_seen <= matched;
      period      <= PERIOD_W'(tracked);
      status      <= final_st;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lmpd_checker.sv -----
`default_nettype none

module lmpd_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           step_valid,
  input wire logic                           step_stall,
  input wire logic                           result_valid,
  input wire logic                           result_stall,
  input wire logic [lmpd_pkg::X_W-1:0]       value,
  input wire logic                           repeat_seen,
  input wire logic [lmpd_pkg::PERIOD_W-1:0]  period,
  input wire logic [lmpd_pkg::STATUS_W-1:0]  status
);
  import lmpd_pkg::*;

  // A stalled result beat stays offered.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_payload_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      $stable(value) && $stable(repeat_seen) && $stable(period) && $stable(status))
    else $error("result payload changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result beat offered after reset");

  // One step at a time: an accepted step holds off the next.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    step_valid && !step_stall |=> step_stall)
    else $error("second step taken while one is in flight");

  // A settled step never reports a repeat.
  a_settled_no_repeat: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == ST_SETTLED) |-> !repeat_seen)
    else $error("settled result reports a repeat");

endmodule

bind logistic_map_period_detector lmpd_checker u_lmpd_checker (.*);

`default_nettype wire
